>>> sv/keyed_rate_limiter_lockout_unit_assert.svh
// Assertion macros for the keyed rate limiter lockout unit.
// Uses i_clk and i_rst_n of the including module.
`ifndef KEYED_RATE_LIMITER_LOCKOUT_UNIT_ASSERT_SVH
`define KEYED_RATE_LIMITER_LOCKOUT_UNIT_ASSERT_SVH

// same-cycle implication
`define KRL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("krl assertion failed");

// next-cycle implication
`define KRL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("krl assertion failed");

`endif

>>> sv/krl_pkg.sv
// Shared types and constants of the keyed rate limiter lockout unit.
// No dependencies.
package krl_pkg;

    typedef enum logic [1:0] {
        ACT_CHECK = 2'd0,
        ACT_RESET = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_SWEEP = 2'd3
    } t_action;

    localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd0;
    localparam logic [1:0] REG_WINDOW       = 2'd1;
    localparam logic [1:0] REG_BLOCK        = 2'd2;
    localparam logic [1:0] REG_IDLE         = 2'd3;

    localparam logic [7:0]  DEF_MAX_ATTEMPTS = 8'd5;
    localparam logic [31:0] DEF_WINDOW       = 32'd900;   // 15 minutes
    localparam logic [31:0] DEF_BLOCK        = 32'd3600;  // 1 hour
    localparam logic [31:0] DEF_IDLE         = 32'd86400; // 24 hours

    localparam logic [8:0] CNT_MAX = 9'd511;

    typedef struct packed {
        logic [7:0]  max_attempts;
        logic [31:0] window_seconds;
        logic [31:0] block_seconds;
        logic [31:0] idle_seconds;
    } t_cfg;

    // request token moving down the cell row
    typedef struct packed {
        logic        vld;
        logic        ins;      // second pass: place a new key
        logic        done;     // new key placed
        t_action     action;
        logic [31:0] key;
        logic        found;
        logic        allowed;
        logic [8:0]  cnt;
        logic        blk;
    } t_tok;

endpackage

>>> sv/krl_cell.sv
// One table entry of the rate limiter plus its stage of the token row.
// Depends on krl_pkg.
module krl_cell #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  krl_pkg::t_cfg        i_cfg,
    input  krl_pkg::t_tok        i_tok,
    input  logic [TIME_BITS-1:0] i_now,
    output krl_pkg::t_tok        o_tok,
    output logic [TIME_BITS-1:0] o_now
);
    import krl_pkg::*;

    localparam int CMPW = TIME_BITS + 33;

    logic                 r_valid, n_valid;
    logic [31:0]          r_key, n_key;
    logic [TIME_BITS-1:0] r_ws, n_ws;
    logic [TIME_BITS-1:0] r_lat, n_lat;
    logic [8:0]           r_cnt, n_cnt;
    logic                 r_blk, n_blk;
    logic [TIME_BITS-1:0] r_bend, n_bend;
    t_tok                 r_tok, n_tok;
    logic [TIME_BITS-1:0] r_now;

    logic                 w_match, w_expired, w_blk1, w_win_over, w_idle_over;
    logic [TIME_BITS-1:0] w_el_win, w_el_idle, w_bend_sat;
    logic [CMPW-1:0]      w_sum;
    logic [8:0]           w_cnt1, w_cnt_inc;

    always_comb begin
        w_match     = r_valid && (r_key == i_tok.key);
        w_el_win    = (i_now > r_ws) ? (i_now - r_ws) : '0;
        w_el_idle   = (i_now > r_lat) ? (i_now - r_lat) : '0;
        w_win_over  = CMPW'(w_el_win) > CMPW'(i_cfg.window_seconds);
        w_idle_over = CMPW'(w_el_idle) > CMPW'(i_cfg.idle_seconds);
        w_sum       = CMPW'(i_now) + CMPW'(i_cfg.block_seconds);
        w_bend_sat  = (|w_sum[CMPW-1:TIME_BITS]) ? '1 : w_sum[TIME_BITS-1:0];
        w_expired   = r_blk && (i_now > r_bend);
        w_blk1      = r_blk && !w_expired;
        w_cnt1      = w_expired ? 9'd0 : r_cnt;
        w_cnt_inc   = (w_cnt1 == CNT_MAX) ? w_cnt1 : w_cnt1 + 9'd1;
    end

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_ws    = r_ws;
        n_lat   = r_lat;
        n_cnt   = r_cnt;
        n_blk   = r_blk;
        n_bend  = r_bend;
        n_tok   = i_tok;
        if (i_tok.vld) begin
            if (!i_tok.ins) begin
                unique case (i_tok.action)
                    ACT_CHECK: begin
                        if (w_match) begin
                            n_tok.found = 1'b1;
                            n_blk       = w_blk1;
                            n_cnt       = w_cnt1;
                            if (w_blk1) begin
                                n_tok.allowed = 1'b0;
                            end else if (w_win_over) begin
                                n_ws          = i_now;
                                n_lat         = i_now;
                                n_cnt         = 9'd1;
                                n_tok.allowed = 1'b1;
                            end else begin
                                n_cnt = w_cnt_inc;
                                n_lat = i_now;
                                if (w_cnt_inc > {1'b0, i_cfg.max_attempts}) begin
                                    n_blk         = 1'b1;
                                    n_bend        = w_bend_sat;
                                    n_tok.allowed = 1'b0;
                                end else begin
                                    n_tok.allowed = 1'b1;
                                end
                            end
                            n_tok.cnt = n_cnt;
                            n_tok.blk = n_blk;
                        end
                    end
                    ACT_RESET: begin
                        if (w_match) begin
                            n_tok.found = 1'b1;
                            n_valid     = 1'b0;
                        end
                    end
                    ACT_QUERY: begin
                        if (w_match) begin
                            n_tok.found = 1'b1;
                            n_tok.cnt   = r_cnt;
                            n_tok.blk   = r_blk;
                        end
                    end
                    ACT_SWEEP: begin
                        if (r_valid && w_idle_over) begin
                            n_valid = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end else if (!i_tok.done && !r_valid) begin
                n_valid    = 1'b1;
                n_key      = i_tok.key;
                n_ws       = i_now;
                n_lat      = i_now;
                n_cnt      = 9'd1;
                n_blk      = 1'b0;
                n_bend     = '0;
                n_tok.done = 1'b1;
                n_tok.cnt  = 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_ws   <= n_ws;
        r_lat  <= n_lat;
        r_cnt  <= n_cnt;
        r_blk  <= n_blk;
        r_bend <= n_bend;
        r_now  <= i_now;
    end

    assign o_tok = r_tok;
    assign o_now = r_now;

endmodule

>>> sv/keyed_rate_limiter_lockout_unit.sv
// Keyed fixed-window rate limiter with lockout: top level.
// Depends on krl_pkg, krl_cell and keyed_rate_limiter_lockout_unit_assert.svh.
//
// Usage:
//   s_axis carries one request word: tuser = action, tdata = key and time.
//   m_axis returns one result word per request.
//   i_cfg_* writes a configuration register and is always ready. It must be
//   written only while no request is in flight; the block does not enforce it.
// The table is a row of TABLE_ENTRIES cells, one entry each. A request token
// walks the row one cell per cycle, matching, updating or sweeping in place.
// A check of an unknown key makes a second walk to claim the first free cell.
// One request is in the row at a time: s_axis_tready drops from accept until
// the result reaches the output stage, so no new word is accepted while a
// request walks the row or waits in the holding stage.
// The output register and a one-word holding stage let the next request be
// accepted while a result waits on a stalled m_axis_tready.
// Reset clears all entries (valid bits), restores default configuration
// and empties the row and output stage.
module keyed_rate_limiter_lockout_unit #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TIME_BITS     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] now
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] allowed, [1] found, [10:2] attempt_count,
                                        // [11] blocked, [12] table_full, [15:13] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import krl_pkg::*;

    t_cfg                 r_cfg, n_cfg;
    logic                 r_busy, n_busy;
    logic                 r_out_vld, n_out_vld;
    logic [15:0]          r_out_data, n_out_data;
    logic                 r_hold_vld, n_hold_vld;
    logic [15:0]          r_hold_data, n_hold_data;

    t_tok                 w_tok [TABLE_ENTRIES+1];
    logic [TIME_BITS-1:0] w_now [TABLE_ENTRIES+1];
    t_tok                 w_head;
    logic [TIME_BITS-1:0] w_head_now;
    logic [TABLE_ENTRIES-1:0] w_vld;
    t_tok                 w_last;
    logic                 w_accept, w_turn, w_fin, w_out_free;
    logic [15:0]          w_res;

    assign s_axis_tready = !r_busy;
    assign o_cfg_ready   = 1'b1;
    assign w_accept      = s_axis_tvalid && !r_busy;
    assign w_last        = w_tok[TABLE_ENTRIES];
    assign w_turn        = w_last.vld && !w_last.ins && (w_last.action == ACT_CHECK)
                           && !w_last.found;
    assign w_fin         = w_last.vld && !w_turn;

    always_comb begin
        w_head     = '0;
        w_head_now = TIME_BITS'(s_axis_tdata[63:32]);
        if (w_accept) begin
            w_head.vld    = 1'b1;
            w_head.action = t_action'(s_axis_tuser);
            w_head.key    = s_axis_tdata[31:0];
        end else if (w_turn) begin
            w_head         = w_last;
            w_head.ins     = 1'b1;
            w_head.done    = 1'b0;
            w_head.allowed = 1'b1;
            w_head_now     = w_now[TABLE_ENTRIES];
        end
    end

    assign w_tok[0] = w_head;
    assign w_now[0] = w_head_now;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        krl_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_tok   (w_tok[g]),
            .i_now   (w_now[g]),
            .o_tok   (w_tok[g+1]),
            .o_now   (w_now[g+1])
        );
        assign w_vld[g] = w_tok[g+1].vld;
    end

    assign w_res = {3'b000, (w_last.ins && !w_last.done), w_last.blk, w_last.cnt,
                    w_last.found, w_last.allowed};

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAX_ATTEMPTS: n_cfg.max_attempts   = i_cfg_data[7:0];
                REG_WINDOW:       n_cfg.window_seconds = i_cfg_data;
                REG_BLOCK:        n_cfg.block_seconds  = i_cfg_data;
                REG_IDLE:         n_cfg.idle_seconds   = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_out_free  = !r_out_vld || m_axis_tready;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_out_data  = r_out_data;
        n_hold_vld  = r_hold_vld;
        n_hold_data = r_hold_data;
        n_busy      = r_busy || w_accept;
        if (w_out_free) begin
            if (r_hold_vld) begin
                n_out_vld  = 1'b1;
                n_out_data = r_hold_data;
                n_hold_vld = 1'b0;
                n_busy     = 1'b0;
            end else if (w_fin) begin
                n_out_vld  = 1'b1;
                n_out_data = w_res;
                n_busy     = 1'b0;
            end
        end else if (w_fin) begin
            n_hold_vld  = 1'b1;
            n_hold_data = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= '{max_attempts: DEF_MAX_ATTEMPTS, window_seconds: DEF_WINDOW,
                            block_seconds: DEF_BLOCK, idle_seconds: DEF_IDLE};
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_cfg      <= n_cfg;
            r_busy     <= n_busy;
            r_out_vld  <= n_out_vld;
            r_hold_vld <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_hold_data <= n_hold_data;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

`include "keyed_rate_limiter_lockout_unit_assert.svh"

    `KRL_ASSERT_NOW(a_one_token, 1'b1, $countones(w_vld) <= 1)
    `KRL_ASSERT_NEXT(a_busy_after_accept, w_accept, r_busy)
    `KRL_ASSERT_NOW(a_hold_behind_out, r_hold_vld, r_out_vld && r_busy)
    `KRL_ASSERT_NOW(a_token_only_busy, w_last.vld, r_busy && !r_hold_vld)

endmodule
